/* hdl/nwrl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwrl_pkg : shared types for the NAT wildcard rule lookup core
// Request and match codes, controller states, rule entry layouts and the
// command and status words between controller and datapath.
// ----------------------------------------------------------------------------
package nwrl_pkg;

   localparam int unsigned IP_W   = 32;
   localparam int unsigned PORT_W = 16;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_LOOKUP = 2'd1,
      REQ_CLEAR  = 2'd2,
      REQ_NONE   = 2'd3
   } req_op_type;

   typedef enum logic [1:0] {
      MATCH_NONE  = 2'd0,
      MATCH_EXACT = 2'd1,
      MATCH_ADDR  = 2'd2,
      MATCH_PORT  = 2'd3
   } match_kind_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE,
      ST_CLEAR,
      ST_RESP
   } state_type;

   // key store entry: valid flag kept alongside the key
   typedef struct packed {
      logic              valid;
      logic [IP_W-1:0]   ip;
      logic [PORT_W-1:0] port;
      logic              ip_any;
      logic              port_any;
   } key_entry_type;

   typedef struct packed {
      logic [IP_W-1:0]   ip;
      logic [PORT_W-1:0] port;
   } target_type;

   // controller -> datapath
   typedef struct packed {
      logic load;    // capture request word, clear flags and address
      logic step;    // read key entry at scan address, advance
      logic sweep;   // invalidate key entry at scan address, advance
      logic commit;  // apply insert write or issue target read
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic last;    // scan address is on the final entry
   } sts_type;

endpackage

/* hdl/nwrl_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwrl_datapath : rule stores, scan pointer and match tracking
// Holds key and target memories, walks the key store one entry a cycle and
// keeps the first hit of every class, then writes or reads a target.
// ----------------------------------------------------------------------------
module nwrl_datapath #(
   parameter int unsigned RULE_ENTRIES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  nwrl_pkg::cmd_type             cmd,
   output nwrl_pkg::sts_type             sts,
   input  logic [1:0]                    req_type,
   input  logic [nwrl_pkg::IP_W-1:0]     req_key_ip,
   input  logic [nwrl_pkg::PORT_W-1:0]   req_key_port,
   input  logic                          req_ip_any,
   input  logic                          req_port_any,
   input  logic [nwrl_pkg::IP_W-1:0]     req_new_ip,
   input  logic [nwrl_pkg::PORT_W-1:0]   req_new_port,
   output logic [1:0]                    rsp_match_kind,
   output logic [nwrl_pkg::IP_W-1:0]     rsp_out_ip,
   output logic [nwrl_pkg::PORT_W-1:0]   rsp_out_port,
   output logic                          rsp_table_full
);

   localparam int unsigned IDX_W = (RULE_ENTRIES > 1) ? $clog2(RULE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RULE_ENTRIES - 1);

   nwrl_pkg::key_entry_type key_mem_ff [RULE_ENTRIES];
   nwrl_pkg::target_type    tgt_mem_ff [RULE_ENTRIES];

   // request word
   nwrl_pkg::req_op_type            op_ff;
   logic [nwrl_pkg::IP_W-1:0]       ip_ff;
   logic [nwrl_pkg::PORT_W-1:0]     port_ff;
   logic                            ip_any_ff;
   logic                            port_any_ff;
   nwrl_pkg::target_type            new_tgt_ff;

   // scan pointer and read pipe
   logic [IDX_W-1:0]                addr_ff, addr_in;
   logic                            rd_vld_ff;
   logic [IDX_W-1:0]                rd_idx_ff;
   nwrl_pkg::key_entry_type         key_rd_ff;
   nwrl_pkg::target_type            tgt_rd_ff;

   // first hit of each class
   logic                            same_ff, free_ff, exact_ff, addr_hit_ff, port_hit_ff;
   logic [IDX_W-1:0]                same_idx_ff, free_idx_ff, exact_idx_ff;
   logic [IDX_W-1:0]                addr_idx_ff, port_idx_ff;

   nwrl_pkg::match_kind_type        kind_ff, kind_in, look_kind;
   logic                            full_ff, full_in;

   logic                            e_same, e_free, e_exact, e_addr, e_port;
   logic                            key_we, tgt_we, tgt_re;
   logic [IDX_W-1:0]                key_wa, tgt_wa, tgt_ra;
   nwrl_pkg::key_entry_type         key_wd;

   assign sts.last = (addr_ff == LAST_IDX);

   // per-entry compare on the word just read
   always_comb begin
      e_same  = 1'b0;
      e_free  = 1'b0;
      e_exact = 1'b0;
      e_addr  = 1'b0;
      e_port  = 1'b0;
      if (rd_vld_ff) begin
         e_free  = !key_rd_ff.valid;
         e_same  = key_rd_ff.valid && key_rd_ff.ip == ip_ff && key_rd_ff.port == port_ff
                   && key_rd_ff.ip_any == ip_any_ff && key_rd_ff.port_any == port_any_ff;
         e_exact = key_rd_ff.valid && !key_rd_ff.ip_any && !key_rd_ff.port_any
                   && key_rd_ff.ip == ip_ff && key_rd_ff.port == port_ff;
         e_addr  = key_rd_ff.valid && !key_rd_ff.ip_any && key_rd_ff.port_any
                   && key_rd_ff.ip == ip_ff;
         e_port  = key_rd_ff.valid && key_rd_ff.ip_any && !key_rd_ff.port_any
                   && key_rd_ff.port == port_ff;
      end
   end

   // commit decisions
   always_comb begin
      look_kind = nwrl_pkg::MATCH_NONE;
      tgt_ra    = port_idx_ff;
      if (exact_ff) begin
         look_kind = nwrl_pkg::MATCH_EXACT;
         tgt_ra    = exact_idx_ff;
      end else if (addr_hit_ff) begin
         look_kind = nwrl_pkg::MATCH_ADDR;
         tgt_ra    = addr_idx_ff;
      end else if (port_hit_ff) begin
         look_kind = nwrl_pkg::MATCH_PORT;
      end

      key_we = cmd.sweep
               || (cmd.commit && op_ff == nwrl_pkg::REQ_INSERT && !same_ff && free_ff);
      key_wa = cmd.sweep ? addr_ff : free_idx_ff;
      key_wd = '0;
      if (!cmd.sweep) begin
         key_wd.valid    = 1'b1;
         key_wd.ip       = ip_ff;
         key_wd.port     = port_ff;
         key_wd.ip_any   = ip_any_ff;
         key_wd.port_any = port_any_ff;
      end

      tgt_we = cmd.commit && op_ff == nwrl_pkg::REQ_INSERT && (same_ff || free_ff);
      tgt_wa = same_ff ? same_idx_ff : free_idx_ff;
      tgt_re = cmd.commit && op_ff == nwrl_pkg::REQ_LOOKUP;

      kind_in = kind_ff;
      full_in = full_ff;
      if (cmd.load) begin
         kind_in = nwrl_pkg::MATCH_NONE;
         full_in = 1'b0;
      end else if (cmd.commit) begin
         kind_in = (op_ff == nwrl_pkg::REQ_LOOKUP) ? look_kind : nwrl_pkg::MATCH_NONE;
         full_in = (op_ff == nwrl_pkg::REQ_INSERT) && !same_ff && !free_ff;
      end

      addr_in = addr_ff;
      if (cmd.load) begin
         addr_in = '0;
      end else if (cmd.step || cmd.sweep) begin
         addr_in = sts.last ? '0 : addr_ff + 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff     <= '0;
         rd_vld_ff   <= 1'b0;
         kind_ff     <= nwrl_pkg::MATCH_NONE;
         full_ff     <= 1'b0;
         same_ff     <= 1'b0;
         free_ff     <= 1'b0;
         exact_ff    <= 1'b0;
         addr_hit_ff <= 1'b0;
         port_hit_ff <= 1'b0;
      end else begin
         addr_ff   <= addr_in;
         rd_vld_ff <= cmd.step;
         kind_ff   <= kind_in;
         full_ff   <= full_in;
         if (cmd.load) begin
            same_ff     <= 1'b0;
            free_ff     <= 1'b0;
            exact_ff    <= 1'b0;
            addr_hit_ff <= 1'b0;
            port_hit_ff <= 1'b0;
         end else begin
            same_ff     <= same_ff     | e_same;
            free_ff     <= free_ff     | e_free;
            exact_ff    <= exact_ff    | e_exact;
            addr_hit_ff <= addr_hit_ff | e_addr;
            port_hit_ff <= port_hit_ff | e_port;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff <= addr_ff;
      if (cmd.load) begin
         op_ff       <= nwrl_pkg::req_op_type'(req_type);
         // wildcard parts of an insert are held as zero
         ip_ff       <= (req_ip_any   && req_type == nwrl_pkg::REQ_INSERT) ? '0 : req_key_ip;
         port_ff     <= (req_port_any && req_type == nwrl_pkg::REQ_INSERT) ? '0 : req_key_port;
         ip_any_ff   <= req_ip_any;
         port_any_ff <= req_port_any;
         new_tgt_ff  <= {req_new_ip, req_new_port};
      end
      if (e_same  && !same_ff)     same_idx_ff  <= rd_idx_ff;
      if (e_free  && !free_ff)     free_idx_ff  <= rd_idx_ff;
      if (e_exact && !exact_ff)    exact_idx_ff <= rd_idx_ff;
      if (e_addr  && !addr_hit_ff) addr_idx_ff  <= rd_idx_ff;
      if (e_port  && !port_hit_ff) port_idx_ff  <= rd_idx_ff;
   end

   // key store
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem_ff[key_wa] <= key_wd;
      end
      if (cmd.step) begin
         key_rd_ff <= key_mem_ff[addr_ff];
      end
   end

   // target store
   always_ff @(posedge clock) begin
      if (tgt_we) begin
         tgt_mem_ff[tgt_wa] <= new_tgt_ff;
      end
      if (tgt_re) begin
         tgt_rd_ff <= tgt_mem_ff[tgt_ra];
      end
   end

   assign rsp_match_kind = kind_ff;
   assign rsp_table_full = full_ff;
   assign rsp_out_ip     = (kind_ff != nwrl_pkg::MATCH_NONE) ? tgt_rd_ff.ip   : '0;
   assign rsp_out_port   = (kind_ff != nwrl_pkg::MATCH_NONE) ? tgt_rd_ff.port : '0;

endmodule

/* hdl/nwrl_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwrl_ctrl : request sequencer
// Dispatches a request word, runs the scan or clearing sweep and raises the
// response strobe for one cycle.
// ----------------------------------------------------------------------------
module nwrl_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [1:0]         req_type,
   input  logic               both_any,
   input  nwrl_pkg::sts_type  sts,
   output nwrl_pkg::cmd_type  cmd,
   output logic               busy,
   output logic               rsp_valid
);

   nwrl_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nwrl_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      busy      = reset || (state_ff != nwrl_pkg::ST_IDLE);
      rsp_valid = (state_ff == nwrl_pkg::ST_RESP);
      case (state_ff)
         nwrl_pkg::ST_INIT: begin
            cmd.sweep = 1'b1;
            if (sts.last) state_in = nwrl_pkg::ST_IDLE;
         end
         nwrl_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               case (req_type)
                  nwrl_pkg::REQ_INSERT:
                     state_in = both_any ? nwrl_pkg::ST_RESP : nwrl_pkg::ST_SCAN;
                  nwrl_pkg::REQ_LOOKUP: state_in = nwrl_pkg::ST_SCAN;
                  nwrl_pkg::REQ_CLEAR:  state_in = nwrl_pkg::ST_CLEAR;
                  default:              state_in = nwrl_pkg::ST_RESP;
               endcase
            end
         end
         nwrl_pkg::ST_SCAN: begin
            cmd.step = 1'b1;
            if (sts.last) state_in = nwrl_pkg::ST_DRAIN;
         end
         nwrl_pkg::ST_DRAIN:  state_in = nwrl_pkg::ST_DECIDE;
         nwrl_pkg::ST_DECIDE: begin
            cmd.commit = 1'b1;
            state_in   = nwrl_pkg::ST_RESP;
         end
         nwrl_pkg::ST_CLEAR: begin
            cmd.sweep = 1'b1;
            if (sts.last) state_in = nwrl_pkg::ST_RESP;
         end
         nwrl_pkg::ST_RESP:   state_in = nwrl_pkg::ST_IDLE;
         default:             state_in = nwrl_pkg::ST_INIT;
      endcase
   end

endmodule

/* hdl/nat_wildcard_rule_lookup_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nat_wildcard_rule_lookup_core : NAT translation rule table with wildcards
// Insert, lookup and clear requests against a table of address/port rules,
// either part of which may be a wildcard.
// ----------------------------------------------------------------------------
//  channel   | handshake          | word
//  ----------+--------------------+-----------------------------------------
//  request   | start, busy        | req_type, key ip/port, wildcards, target
//  response  | rsp_valid (strobe) | match kind, out ip/port, table full
//
//  Insert and lookup walk the key store one entry per cycle through its
//  single read port, then pass the drain and decide states. Clear sweeps
//  the key store one entry per cycle. An insert with both parts wildcarded,
//  or an unused request code, answers in the cycle after acceptance. One
//  request is in flight at a time; busy drops after the strobe. After reset
//  a clearing pass over every key entry runs with busy high. The response
//  strobe lasts one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module nat_wildcard_rule_lookup_core #(
   parameter int unsigned RULE_ENTRIES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_type,
   input  logic [nwrl_pkg::IP_W-1:0]     req_key_ip,
   input  logic [nwrl_pkg::PORT_W-1:0]   req_key_port,
   input  logic                          req_ip_any,
   input  logic                          req_port_any,
   input  logic [nwrl_pkg::IP_W-1:0]     req_new_ip,
   input  logic [nwrl_pkg::PORT_W-1:0]   req_new_port,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_match_kind,
   output logic [nwrl_pkg::IP_W-1:0]     rsp_out_ip,
   output logic [nwrl_pkg::PORT_W-1:0]   rsp_out_port,
   output logic                          rsp_table_full
);

   nwrl_pkg::cmd_type cmd;
   nwrl_pkg::sts_type sts;

   // sequencer: dispatch, scan/sweep pacing, response strobe
   nwrl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_type  (req_type),
      .both_any  (req_ip_any & req_port_any),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // stores, first-hit tracking and response word
   nwrl_datapath #(
      .RULE_ENTRIES (RULE_ENTRIES)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_type       (req_type),
      .req_key_ip     (req_key_ip),
      .req_key_port   (req_key_port),
      .req_ip_any     (req_ip_any),
      .req_port_any   (req_port_any),
      .req_new_ip     (req_new_ip),
      .req_new_port   (req_new_port),
      .rsp_match_kind (rsp_match_kind),
      .rsp_out_ip     (rsp_out_ip),
      .rsp_out_port   (rsp_out_port),
      .rsp_table_full (rsp_table_full)
   );

endmodule

/* hdl/nwrl_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwrl_checker : port-level checks for the rule lookup core
// Sequencing and response-word consistency seen at the top-level ports.
// ----------------------------------------------------------------------------
module nwrl_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  rsp_match_kind,
   input logic [31:0] rsp_out_ip,
   input logic [15:0] rsp_out_port,
   input logic        rsp_table_full,
   input logic        rsp_valid
);

   // an accepted word keeps the core busy until its response
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("core not busy after accepting a word");

   // a response only ends a request in flight
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response strobe while idle");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_no_match_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_match_kind == 2'd0) |-> (rsp_out_ip == '0 && rsp_out_port == '0))
      else $error("translation present without a match");

   a_full_no_match: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_table_full) |-> rsp_match_kind == 2'd0)
      else $error("table full flagged with a match kind");

endmodule

bind nat_wildcard_rule_lookup_core nwrl_checker u_nwrl_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_match_kind (rsp_match_kind),
   .rsp_out_ip     (rsp_out_ip),
   .rsp_out_port   (rsp_out_port),
   .rsp_table_full (rsp_table_full),
   .rsp_valid      (rsp_valid)
);

/* sim/nat_rule_table_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nat_rule_table_checker : response checker for the NAT rule table
// Keeps its own copy of the rule table, works out the answer word for every
// accepted request and compares each strobed response against the oldest
// answer still due.
// ----------------------------------------------------------------------------
module nat_rule_table_checker #(
   parameter int unsigned ENTRIES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [1:0]                    req_type,
   input  logic [nwrl_pkg::IP_W-1:0]     req_key_ip,
   input  logic [nwrl_pkg::PORT_W-1:0]   req_key_port,
   input  logic                          req_ip_any,
   input  logic                          req_port_any,
   input  logic [nwrl_pkg::IP_W-1:0]     req_new_ip,
   input  logic [nwrl_pkg::PORT_W-1:0]   req_new_port,
   input  logic                          rsp_valid,
   input  logic [1:0]                    rsp_match_kind,
   input  logic [nwrl_pkg::IP_W-1:0]     rsp_out_ip,
   input  logic [nwrl_pkg::PORT_W-1:0]   rsp_out_port,
   input  logic                          rsp_table_full,
   output int                            fail_count,
   output int                            outstanding
);
   import nwrl_pkg::*;

   typedef struct packed {
      match_kind_type    kind;
      logic [IP_W-1:0]   ip;
      logic [PORT_W-1:0] port;
      logic              full;
   } answer_type;

   // shadow rule table
   logic              rule_live    [ENTRIES];
   logic [IP_W-1:0]   rule_ip      [ENTRIES];
   logic [PORT_W-1:0] rule_port    [ENTRIES];
   logic              rule_ip_any  [ENTRIES];
   logic              rule_port_any[ENTRIES];
   logic [IP_W-1:0]   rule_to_ip   [ENTRIES];
   logic [PORT_W-1:0] rule_to_port [ENTRIES];

   answer_type due_answers[$];
   int         errs = 0;

   assign fail_count = errs;

   // applies one request to the shadow table and returns its answer word
   function automatic answer_type serve_request(
      input logic [1:0]        op,
      input logic [IP_W-1:0]   key_ip,
      input logic [PORT_W-1:0] key_port,
      input logic              ip_wild,
      input logic              port_wild,
      input logic [IP_W-1:0]   to_ip,
      input logic [PORT_W-1:0] to_port
   );
      answer_type        a;
      int                i;
      int                slot;
      int                hit_exact;
      int                hit_addr;
      int                hit_port;
      int                hit;
      bit                done;
      logic [IP_W-1:0]   kip;
      logic [PORT_W-1:0] kport;

      a.kind = MATCH_NONE;
      a.ip   = '0;
      a.port = '0;
      a.full = 1'b0;
      case (op)
         REQ_INSERT: begin
            if (!(ip_wild && port_wild)) begin
               // wildcard part held as zero so that keys compare cleanly
               kip   = ip_wild   ? '0 : key_ip;
               kport = port_wild ? '0 : key_port;
               slot  = -1;
               done  = 1'b0;
               for (i = 0; i < ENTRIES && !done; i++) begin
                  if (rule_live[i] && rule_ip[i] == kip && rule_port[i] == kport &&
                      rule_ip_any[i] == ip_wild && rule_port_any[i] == port_wild) begin
                     rule_to_ip[i]   = to_ip;
                     rule_to_port[i] = to_port;
                     done            = 1'b1;
                  end else if (!rule_live[i] && slot < 0) begin
                     slot = i;
                  end
               end
               if (!done) begin
                  if (slot < 0) begin
                     a.full = 1'b1;
                  end else begin
                     rule_live[slot]     = 1'b1;
                     rule_ip[slot]       = kip;
                     rule_port[slot]     = kport;
                     rule_ip_any[slot]   = ip_wild;
                     rule_port_any[slot] = port_wild;
                     rule_to_ip[slot]    = to_ip;
                     rule_to_port[slot]  = to_port;
                  end
               end
            end
         end
         REQ_LOOKUP: begin
            hit_exact = -1;
            hit_addr  = -1;
            hit_port  = -1;
            for (i = 0; i < ENTRIES; i++) begin
               if (rule_live[i]) begin
                  if (!rule_ip_any[i] && !rule_port_any[i]) begin
                     if (rule_ip[i] == key_ip && rule_port[i] == key_port && hit_exact < 0)
                        hit_exact = i;
                  end else if (!rule_ip_any[i]) begin
                     if (rule_ip[i] == key_ip && hit_addr < 0)
                        hit_addr = i;
                  end else if (!rule_port_any[i]) begin
                     if (rule_port[i] == key_port && hit_port < 0)
                        hit_port = i;
                  end
               end
            end
            hit = -1;
            if (hit_exact >= 0) begin
               a.kind = MATCH_EXACT;
               hit    = hit_exact;
            end else if (hit_addr >= 0) begin
               a.kind = MATCH_ADDR;
               hit    = hit_addr;
            end else if (hit_port >= 0) begin
               a.kind = MATCH_PORT;
               hit    = hit_port;
            end
            if (hit >= 0) begin
               a.ip   = rule_to_ip[hit];
               a.port = rule_to_port[hit];
            end
         end
         REQ_CLEAR: begin
            for (i = 0; i < ENTRIES; i++)
               rule_live[i] = 1'b0;
         end
         default: ;
      endcase
      return a;
   endfunction

   function automatic void report(input string what, input logic [IP_W-1:0] want,
                                  input logic [IP_W-1:0] got);
      errs++;
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
   endfunction

   always @(posedge clock) begin : watch
      answer_type want;
      int         i;
      if (reset) begin
         for (i = 0; i < ENTRIES; i++)
            rule_live[i] = 1'b0;
         due_answers.delete();
      end else begin
         if (rsp_valid === 1'b1) begin
            if (due_answers.size() == 0) begin
               errs++;
               $display("%0t ns: response word mismatch, expected none, %s",
                        $time, "got");
               $display("   kind %0d ip 0x%0h port 0x%0h full %0b",
                        rsp_match_kind, rsp_out_ip, rsp_out_port, rsp_table_full);
            end else begin
               want = due_answers.pop_front();
               if (rsp_match_kind !== want.kind)
                  report("match_kind", IP_W'(want.kind), IP_W'(rsp_match_kind));
               if (rsp_out_ip !== want.ip)
                  report("out_ip", want.ip, rsp_out_ip);
               if (rsp_out_port !== want.port)
                  report("out_port", IP_W'(want.port), IP_W'(rsp_out_port));
               if (rsp_table_full !== want.full)
                  report("table_full", IP_W'(want.full), IP_W'(rsp_table_full));
            end
         end
         if (start === 1'b1 && busy === 1'b0)
            due_answers.push_back(serve_request(req_type, req_key_ip, req_key_port,
                                                req_ip_any, req_port_any,
                                                req_new_ip, req_new_port));
      end
      outstanding <= due_answers.size();
   end

endmodule

/* sim/tb_nat_wildcard_rule_lookup_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nat_wildcard_rule_lookup_core : regression for the NAT rule table core
// A directed run over the field extremes, every request and the wildcard,
// overwrite and ignore cases, then rounds of random rule traffic built from
// small key pools so that lookups hit and the table fills up. The checker
// beside the core predicts and compares every response word.
// ----------------------------------------------------------------------------
module tb_nat_wildcard_rule_lookup_core;
   import nwrl_pkg::*;

   localparam int unsigned ENTRIES     = 64;
   // insert and lookup answer after a full walk of the key store
   localparam int unsigned STROBE_LAG  = ENTRIES + 3;
   localparam int unsigned ITEM_TARGET = 1300;
   // well past the slowest legal run: about 1300 words with the longest gaps
   localparam longint      RUN_LIMIT_NS = 64'd10_000_000;

   logic                clock        = 1'b0;
   logic                reset        = 1'b1;
   logic                start        = 1'b0;
   logic                busy;
   logic [1:0]          req_type     = REQ_NONE;
   logic [IP_W-1:0]     req_key_ip   = '0;
   logic [PORT_W-1:0]   req_key_port = '0;
   logic                req_ip_any   = 1'b0;
   logic                req_port_any = 1'b0;
   logic [IP_W-1:0]     req_new_ip   = '0;
   logic [PORT_W-1:0]   req_new_port = '0;
   logic                rsp_valid;
   logic [1:0]          rsp_match_kind;
   logic [IP_W-1:0]     rsp_out_ip;
   logic [PORT_W-1:0]   rsp_out_port;
   logic                rsp_table_full;

   int fail_count;
   int outstanding;

   int                sent     = 0;   // request words accepted so far
   int                idle_pct = 0;   // chance per cycle that the sender idles
   logic [IP_W-1:0]   ip_pool  [8];
   logic [PORT_W-1:0] port_pool[8];

   initial forever #4 clock = ~clock;

   nat_wildcard_rule_lookup_core #(
      .RULE_ENTRIES(ENTRIES)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_key_ip     (req_key_ip),
      .req_key_port   (req_key_port),
      .req_ip_any     (req_ip_any),
      .req_port_any   (req_port_any),
      .req_new_ip     (req_new_ip),
      .req_new_port   (req_new_port),
      .rsp_valid      (rsp_valid),
      .rsp_match_kind (rsp_match_kind),
      .rsp_out_ip     (rsp_out_ip),
      .rsp_out_port   (rsp_out_port),
      .rsp_table_full (rsp_table_full)
   );

   nat_rule_table_checker #(
      .ENTRIES(ENTRIES)
   ) rule_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_key_ip     (req_key_ip),
      .req_key_port   (req_key_port),
      .req_ip_any     (req_ip_any),
      .req_port_any   (req_port_any),
      .req_new_ip     (req_new_ip),
      .req_new_port   (req_new_port),
      .rsp_valid      (rsp_valid),
      .rsp_match_kind (rsp_match_kind),
      .rsp_out_ip     (rsp_out_ip),
      .rsp_out_port   (rsp_out_port),
      .rsp_table_full (rsp_table_full),
      .fail_count     (fail_count),
      .outstanding    (outstanding)
   );

   // Presents one request word and returns at the edge that accepts it.
   // Start is left high, so back-to-back words need no second assignment.
   task automatic issue(input logic [1:0] op, input logic [IP_W-1:0] kip,
                        input logic [PORT_W-1:0] kport, input logic ipw,
                        input logic portw, input logic [IP_W-1:0] nip,
                        input logic [PORT_W-1:0] nport);
      start        <= 1'b1;
      req_type     <= op;
      req_key_ip   <= kip;
      req_key_port <= kport;
      req_ip_any   <= ipw;
      req_port_any <= portw;
      req_new_ip   <= nip;
      req_new_port <= nport;
      do @(posedge clock); while (busy !== 1'b0);
      sent++;
   endtask

   // Sender idling after an accepted word. Short gaps mostly, now and then a
   // long one so that start rises at every point of the busy window.
   // With hold set the sender also waits for every due response.
   task automatic sender_gap(input bit hold);
      int n;
      n = 0;
      if (idle_pct > 0) begin
         while (n < 20 && $urandom_range(99) < idle_pct)
            n++;
         if ($urandom_range(99) < idle_pct / 8)
            n += $urandom_range(1, STROBE_LAG + 8);
      end
      if (n > 0 || hold) begin
         start <= 1'b0;
         if (hold)
            do @(posedge clock); while (outstanding != 0);
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic fresh_pools;
      int i;
      for (i = 0; i < 8; i++) begin
         ip_pool[i]   = $urandom;
         port_pool[i] = PORT_W'($urandom);
      end
      // keep the field extremes in play now and then
      if ($urandom_range(3) == 0) ip_pool[0]   = '0;
      if ($urandom_range(3) == 0) ip_pool[1]   = '1;
      if ($urandom_range(3) == 0) port_pool[0] = '0;
      if ($urandom_range(3) == 0) port_pool[1] = '1;
   endtask

   // One random word. Keys come from the small pools so that rules collide,
   // overwrite and fill the table; a slice of the traffic is plain noise.
   task automatic random_word(input int insert_pct);
      int                pick;
      int                shape;
      logic [1:0]        op;
      logic [IP_W-1:0]   kip;
      logic [PORT_W-1:0] kport;
      logic              ipw;
      logic              portw;
      pick  = $urandom_range(99);
      kip   = ip_pool[3'($urandom_range(7))];
      kport = port_pool[3'($urandom_range(7))];
      if (pick < 6) begin
         op = ($urandom_range(1) != 0) ? 2'(REQ_NONE) : 2'($urandom_range(3));
         issue(op, $urandom, PORT_W'($urandom), 1'($urandom_range(1)),
               1'($urandom_range(1)), $urandom, PORT_W'($urandom));
      end else if (pick < 6 + insert_pct * 94 / 100) begin
         shape = $urandom_range(19);
         ipw   = (shape >= 15);
         portw = (shape >= 12 && shape < 15) || (shape >= 18);
         // the wildcard part carries rubbish that must be dropped
         if (ipw)   kip   = $urandom;
         if (portw) kport = PORT_W'($urandom);
         issue(REQ_INSERT, kip, kport, ipw, portw, $urandom, PORT_W'($urandom));
      end else begin
         if ($urandom_range(9) == 0) kip   = $urandom;
         if ($urandom_range(9) == 0) kport = PORT_W'($urandom);
         issue(REQ_LOOKUP, kip, kport, 1'($urandom_range(1)), 1'($urandom_range(1)),
               $urandom, PORT_W'($urandom));
      end
   endtask

   initial begin
      #(RUN_LIMIT_NS);
      $display("nat_wildcard_rule_lookup_core regression: fail");
      $finish;
   end

   initial begin : stimulus
      int round;
      int len;
      int k;
      int insert_pct;
      int phase_pct[3];

      phase_pct[0] = 0;
      phase_pct[1] = 46;
      phase_pct[2] = 20;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part, no idling ----
      // empty table, lowest key
      issue(REQ_LOOKUP, '0, '0, 1'b0, 1'b0, '0, '0);
      // exact rule at the top of both fields, target at the top too
      issue(REQ_INSERT, '1, '1, 1'b0, 1'b0, '1, '1);
      issue(REQ_LOOKUP, '1, '1, 1'b0, 1'b0, '0, '0);
      // address rule; its port is rubbish and must be stored as zero
      issue(REQ_INSERT, '1, 16'h1234, 1'b0, 1'b1, '0, '0);
      issue(REQ_LOOKUP, '1, '0, 1'b0, 1'b0, '0, '0);
      // exact rule wins over the address rule
      issue(REQ_LOOKUP, '1, '1, 1'b0, 1'b0, '0, '0);
      // port rule with rubbish in the address part
      issue(REQ_INSERT, 32'hDEAD_BEEF, '0, 1'b1, 1'b0, 32'hA5A5_A5A5, 16'h5A5A);
      issue(REQ_LOOKUP, 32'h1234_5678, '0, 1'b0, 1'b0, '0, '0);
      // address rule wins over the port rule
      issue(REQ_LOOKUP, '1, '0, 1'b0, 1'b0, '0, '0);
      // both parts wildcarded: accepted, table untouched
      issue(REQ_INSERT, 32'h0BAD_F00D, 16'h0001, 1'b1, 1'b1, '1, '1);
      issue(REQ_LOOKUP, '0, 16'h0001, 1'b0, 1'b0, '0, '0);
      // same key again overwrites the target
      issue(REQ_INSERT, '1, '1, 1'b0, 1'b0, 32'h0102_0304, 16'h0506);
      issue(REQ_LOOKUP, '1, '1, 1'b0, 1'b0, '0, '0);
      // flags on a lookup are ignored
      issue(REQ_LOOKUP, '1, '1, 1'b1, 1'b1, 32'hFFFF_0000, 16'h00FF);
      // unused request code answers zero
      issue(REQ_NONE, 32'hCAFE_F00D, 16'hBEEF, 1'b1, 1'b1, '1, '1);
      // port rule with other rubbish in the address is the same key
      issue(REQ_INSERT, 32'h1111_1111, '0, 1'b1, 1'b0, 32'h7777_0000, 16'h8001);
      issue(REQ_LOOKUP, '0, '0, 1'b0, 1'b0, '0, '0);
      // clear with flags set, then nothing matches
      issue(REQ_CLEAR, '1, '1, 1'b1, 1'b1, '1, '1);
      issue(REQ_LOOKUP, '1, '1, 1'b0, 1'b0, '0, '0);
      issue(REQ_LOOKUP, '0, '0, 1'b0, 1'b0, '0, '0);
      // exact rule at the bottom of both fields
      issue(REQ_INSERT, '0, '0, 1'b0, 1'b0, 32'h8000_0000, 16'h8000);
      issue(REQ_LOOKUP, '0, '0, 1'b0, 1'b0, '0, '0);
      issue(REQ_CLEAR, '0, '0, 1'b0, 1'b0, '0, '0);

      // ---- random rounds ----
      // each round opens with fresh key pools and mostly a clear; long
      // insert-heavy rounds run the table full
      round = 0;
      while (sent < ITEM_TARGET) begin
         fresh_pools();
         idle_pct = phase_pct[2'((sent / 200) % 3)];
         // every fourth round the sender drains the core first
         sender_gap(round % 4 == 0);
         if ($urandom_range(3) != 0) begin
            issue(REQ_CLEAR, $urandom, PORT_W'($urandom), 1'($urandom_range(1)),
                  1'($urandom_range(1)), $urandom, PORT_W'($urandom));
            sender_gap(1'b0);
         end
         len        = ($urandom_range(2) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(120, 220);
         insert_pct = $urandom_range(30, 85);
         for (k = 0; k < len && sent < ITEM_TARGET; k++) begin
            idle_pct = phase_pct[2'((sent / 200) % 3)];
            random_word(insert_pct);
            sender_gap(1'b0);
         end
         round++;
      end

      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      // any stray strobe after the last answer still counts as a failure
      repeat (STROBE_LAG + 8) @(posedge clock);
      if (fail_count == 0)
         $display("nat_wildcard_rule_lookup_core regression: pass");
      else
         $display("nat_wildcard_rule_lookup_core regression: fail");
      $finish;
   end

endmodule
